### rtl/core/isim_pkg.sv
// shared types and codes for the interval set insert and merge block
package isim_pkg;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_BAD_RANGE = 3'd2,
    ST_READ_OK   = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_SCAN = 5'b00100,
    S_FIN  = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  localparam int unsigned PointW = 32;
  localparam int unsigned EntryW = 2 * PointW;

endpackage

### rtl/core/interval_set_insert_merge.sv
// top level of the interval set insert and merge block
//
// Input channel (in_valid_i/in_ready_o) takes one item: an insert of
// [interval_start_i, interval_end_i] or a read of the entry at entry_index_i.
// Output channel (out_valid_o/out_ready_i) returns one result per item.
// The set lives in two ping-pong rams of CAPACITY entries; an insert reads
// the current bank one entry per cycle, none in the cycle that places the
// merged interval ahead of a kept entry, and writes the compacted, merged
// set into the other bank, which becomes current unless the insert overflows.
// An insert passes through S_SCAN, S_FIN and S_DONE, a read through S_READ
// and S_DONE; a bad range goes straight to S_DONE. The ram read port and
// the one write port per cycle set the insert time.
// A new item is taken once the previous one has its result registered,
// even while that result still waits on out_ready_i; a finished result
// waits in its final state while the output register is still occupied.
// Reset empties the set; ram contents are not cleared.
module interval_set_insert_merge #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [31:0] interval_start_i,
  input  logic [31:0] interval_end_i,
  input  logic [3:0]  entry_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [31:0] out_start_o,
  output logic [31:0] out_end_o,
  output logic [4:0]  absorbed_count_o,
  output logic [4:0]  held_count_o
);
  import isim_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] Cap = CW'(CAPACITY);

  state_e             state_q, state_d;
  logic               bank_q;
  logic [CW-1:0]      count_q, rd_idx_q, n_q, k_q;
  logic               pend_q, placed_q, bad_q, hit_q, act_q;
  logic [31:0]        a_q, b_q, ms_q, me_q;

  logic               out_valid_q;
  status_e            res_status_q;
  logic [31:0]        res_start_q, res_end_q;
  logic [4:0]         res_abs_q, res_held_q;

  logic               ram_re, ram_we;
  logic [AW-1:0]      ram_raddr, ram_waddr;
  logic [EntryW-1:0]  ram_wdata;
  logic [EntryW-1:0]  rdata0, rdata1, rdata;
  logic [31:0]        rd_s, rd_e;
  logic               ovl, place_now, issue, ovf, out_free;
  logic [AW+3:0]      idx_ext;
  logic [CW+3:0]      idx_cmp, cnt_cmp;
  logic [CW+4:0]      cnt_mask, k_mask, n_mask;

  assign rdata = bank_q ? rdata1 : rdata0;
  assign rd_s  = rdata[EntryW-1:PointW];
  assign rd_e  = rdata[PointW-1:0];

  assign ovl       = (rd_s <= b_q) && (a_q <= rd_e);
  assign place_now = (state_q == S_SCAN) && pend_q && !ovl && !placed_q && (rd_s > b_q);
  assign issue     = (state_q == S_SCAN) && (rd_idx_q < count_q) && !place_now;

  assign idx_ext = {{AW{1'b0}}, entry_index_i};
  assign idx_cmp = {{CW{1'b0}}, entry_index_i};
  assign cnt_cmp = {4'b0, count_q};

  assign ovf = ({1'b0, count_q} + 1'b1) > ({1'b0, Cap} + {1'b0, k_q});
  assign out_free = !out_valid_q || out_ready_i;

  assign cnt_mask = {5'b0, count_q};
  assign k_mask   = {5'b0, k_q};
  assign n_mask   = {5'b0, n_q};

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = rd_idx_q[AW-1:0];
    ram_we    = 1'b0;
    ram_waddr = n_q[AW-1:0];
    ram_wdata = {ms_q, me_q};
    state_d   = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (action_i) begin
            ram_re    = 1'b1;
            ram_raddr = idx_ext[AW-1:0];
            state_d   = S_READ;
          end else if (interval_start_i > interval_end_i) begin
            state_d = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_READ: state_d = S_DONE;
      S_SCAN: begin
        ram_re = issue;
        if (pend_q && !ovl && (n_q < Cap)) begin
          ram_we    = 1'b1;
          ram_wdata = place_now ? {ms_q, me_q} : rdata;
        end
        if (!issue && !place_now && !pend_q && (rd_idx_q == count_q)) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        ram_we  = !placed_q && (n_q < Cap);
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  isim_ram #(.Width(EntryW), .Depth(CAPACITY), .AddrW(AW)) u_bank0 (
    .clk_i   (clk_i),
    .we_i    (ram_we && bank_q),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re && !bank_q),
    .raddr_i (ram_raddr),
    .rdata_o (rdata0)
  );

  isim_ram #(.Width(EntryW), .Depth(CAPACITY), .AddrW(AW)) u_bank1 (
    .clk_i   (clk_i),
    .we_i    (ram_we && !bank_q),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re && bank_q),
    .raddr_i (ram_raddr),
    .rdata_o (rdata1)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bank_q      <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      placed_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          pend_q   <= 1'b0;
          placed_q <= 1'b0;
        end
        S_SCAN: begin
          pend_q <= issue || place_now;
          if (place_now) placed_q <= 1'b1;
        end
        S_DONE: begin
          if (out_free) begin
            if (!act_q && !bad_q && !ovf) begin
              count_q <= n_q;
              bank_q  <= !bank_q;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        act_q    <= action_i;
        a_q      <= interval_start_i;
        b_q      <= interval_end_i;
        ms_q     <= interval_start_i;
        me_q     <= interval_end_i;
        bad_q    <= interval_start_i > interval_end_i;
        hit_q    <= idx_cmp < cnt_cmp;
        rd_idx_q <= '0;
        n_q      <= '0;
        k_q      <= '0;
      end
      S_SCAN: begin
        if (issue) rd_idx_q <= rd_idx_q + 1'b1;
        if (pend_q) begin
          if (ovl) begin
            if (rd_s < ms_q) ms_q <= rd_s;
            if (rd_e > me_q) me_q <= rd_e;
            k_q <= k_q + 1'b1;
          end else if (n_q < Cap) begin
            n_q <= n_q + 1'b1;
          end
        end
      end
      S_FIN: begin
        if (!placed_q && (n_q < Cap)) n_q <= n_q + 1'b1;
      end
      S_DONE: begin
        if (out_free) begin
          if (act_q) begin
            res_status_q <= hit_q ? ST_READ_OK : ST_EMPTY;
            res_start_q  <= hit_q ? rd_s : '0;
            res_end_q    <= hit_q ? rd_e : '0;
            res_abs_q    <= '0;
            res_held_q   <= cnt_mask[4:0];
          end else if (!bad_q && !ovf) begin
            res_status_q <= ST_INSERTED;
            res_start_q  <= ms_q;
            res_end_q    <= me_q;
            res_abs_q    <= k_mask[4:0];
            res_held_q   <= n_mask[4:0];
          end else begin
            res_status_q <= bad_q ? ST_BAD_RANGE : ST_FULL;
            res_start_q  <= '0;
            res_end_q    <= '0;
            res_abs_q    <= '0;
            res_held_q   <= cnt_mask[4:0];
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = res_status_q;
  assign out_start_o      = res_start_q;
  assign out_end_o        = res_end_q;
  assign absorbed_count_o = res_abs_q;
  assign held_count_o     = res_held_q;

endmodule

### rtl/core/isim_ram.sv
// generic single write port ram with registered read
module isim_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### dv/tb_interval_set_insert_merge.sv
// self-checking testbench for the interval set insert and merge block
module tb_interval_set_insert_merge;
  import isim_pkg::*;

  localparam int unsigned Capacity = 16;
  localparam bit ActInsert = 1'b0;
  localparam bit ActRead = 1'b1;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] span_lo;
    logic [31:0] span_hi;
    logic [4:0]  absorbed;
    logic [4:0]  held;
  } verdict_t;

  typedef struct {
    bit          action;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [3:0]  idx;
    bit          fixed;
    verdict_t    want;
  } stim_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        action_i;
  logic [31:0] interval_start_i;
  logic [31:0] interval_end_i;
  logic [3:0]  entry_index_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  status_o;
  logic [31:0] out_start_o;
  logic [31:0] out_end_o;
  logic [4:0]  absorbed_count_o;
  logic [4:0]  held_count_o;

  logic [31:0] set_lo [Capacity];
  logic [31:0] set_hi [Capacity];
  int unsigned set_size;
  verdict_t    pending_verdicts [$];
  int unsigned error_count;
  bit          hold_off;

  interval_set_insert_merge #(.CAPACITY(Capacity)) dut (.*);

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic verdict_t mk(status_e st, logic [31:0] lo, logic [31:0] hi,
                                  int unsigned absorbed, int unsigned held);
    verdict_t v;
    v.status = st;
    v.span_lo = lo;
    v.span_hi = hi;
    v.absorbed = absorbed[4:0];
    v.held = held[4:0];
    return v;
  endfunction

  function automatic bit hits(int unsigned i, logic [31:0] lo, logic [31:0] hi);
    return set_lo[i] <= hi && lo <= set_hi[i];
  endfunction

  function automatic verdict_t apply_item(bit action, logic [31:0] lo, logic [31:0] hi,
                                          logic [3:0] idx);
    logic [31:0] m_lo, m_hi;
    logic [31:0] n_lo [Capacity];
    logic [31:0] n_hi [Capacity];
    int unsigned k, n;
    bit placed;
    if (action == ActRead) begin
      if (idx < set_size) return mk(ST_READ_OK, set_lo[idx], set_hi[idx], 0, set_size);
      return mk(ST_EMPTY, 0, 0, 0, set_size);
    end
    if (lo > hi) return mk(ST_BAD_RANGE, 0, 0, 0, set_size);
    m_lo = lo;
    m_hi = hi;
    k = 0;
    for (int unsigned i = 0; i < set_size; i++) begin
      if (hits(i, lo, hi)) begin
        if (set_lo[i] < m_lo) m_lo = set_lo[i];
        if (set_hi[i] > m_hi) m_hi = set_hi[i];
        k++;
      end
    end
    if (set_size - k + 1 > Capacity) return mk(ST_FULL, 0, 0, 0, set_size);
    n = 0;
    placed = 1'b0;
    for (int unsigned i = 0; i < set_size; i++) begin
      if (!hits(i, lo, hi)) begin
        if (!placed && set_lo[i] > m_hi) begin
          n_lo[n] = m_lo;
          n_hi[n] = m_hi;
          n++;
          placed = 1'b1;
        end
        n_lo[n] = set_lo[i];
        n_hi[n] = set_hi[i];
        n++;
      end
    end
    if (!placed) begin
      n_lo[n] = m_lo;
      n_hi[n] = m_hi;
      n++;
    end
    for (int unsigned i = 0; i < n; i++) begin
      set_lo[i] = n_lo[i];
      set_hi[i] = n_hi[i];
    end
    set_size = n;
    return mk(ST_INSERTED, m_lo, m_hi, k, n);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    error_count++;
  endtask

  task automatic send_item(bit action, logic [31:0] lo, logic [31:0] hi, logic [3:0] idx,
                           bit fixed, verdict_t want);
    verdict_t v;
    int unsigned gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
          ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 3));
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= action;
    interval_start_i <= lo;
    interval_end_i <= hi;
    entry_index_i <= idx;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    v = apply_item(action, lo, hi, idx);
    if (fixed && v != want) begin
      report_mismatch("table row vs predictor", v[73:42], want[73:42]);
      v = want;
    end
    pending_verdicts.insert(pending_verdicts.size(), v);
  endtask

  function automatic logic [31:0] rnd_point(int unsigned scale);
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom();
      default: return $urandom_range(0, scale);
    endcase
  endfunction

  // receiver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (pending_verdicts.size() == 0) begin
          report_mismatch("unexpected transfer", 32'(status_o), 0);
        end else begin
          verdict_t w;
          w = pending_verdicts.pop_front();
          if (status_o !== w.status)
            report_mismatch("status", 32'(status_o), 32'(w.status));
          if (out_start_o !== w.span_lo) report_mismatch("out_start", out_start_o, w.span_lo);
          if (out_end_o !== w.span_hi) report_mismatch("out_end", out_end_o, w.span_hi);
          if (absorbed_count_o !== w.absorbed)
            report_mismatch("absorbed_count", 32'(absorbed_count_o), 32'(w.absorbed));
          if (held_count_o !== w.held)
            report_mismatch("held_count", 32'(held_count_o), 32'(w.held));
        end
      end
      out_ready_i <= !hold_off && ($urandom_range(0, 3) != 0 || $urandom_range(0, 1) == 0);
    end
  end

  // receiver stalls, one long and then repeated medium ones
  initial begin
    hold_off = 1'b0;
    wait (rst_ni);
    repeat (3000) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off = 1'b0;
    forever begin
      repeat ($urandom_range(150, 600)) @(posedge clk_i);
      hold_off = 1'b1;
      repeat ($urandom_range(10, 40)) @(posedge clk_i);
      hold_off = 1'b0;
    end
  end

  initial begin
    stim_t rows [$];
    stim_t r;
    int unsigned scale;
    logic [31:0] a, b;
    in_valid_i = 1'b0;
    action_i = 1'b0;
    interval_start_i = '0;
    interval_end_i = '0;
    entry_index_i = '0;
    rst_ni = 1'b0;
    error_count = 0;
    set_size = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    rows.insert(rows.size(), '{ActRead, 0, 0, 0, 1, mk(ST_EMPTY, 0, 0, 0, 0)});
    rows.insert(rows.size(), '{ActInsert, 5, 4, 0, 1, mk(ST_BAD_RANGE, 0, 0, 0, 0)});
    rows.insert(rows.size(), '{ActInsert, 32'hFFFF_FFFF, 0, 0, 1,
                               mk(ST_BAD_RANGE, 0, 0, 0, 0)});
    rows.insert(rows.size(), '{ActInsert, 0, 0, 0, 1, mk(ST_INSERTED, 0, 0, 0, 1)});
    rows.insert(rows.size(), '{ActInsert, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1,
                               mk(ST_INSERTED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 2)});
    rows.insert(rows.size(), '{ActRead, 0, 0, 4'd1, 1,
                               mk(ST_READ_OK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 2)});
    rows.insert(rows.size(), '{ActRead, 0, 0, 4'd15, 1, mk(ST_EMPTY, 0, 0, 0, 2)});
    for (int i = 0; i < 14; i++)
      rows.insert(rows.size(), '{ActInsert, 10 * i + 10, 10 * i + 12, 0, 0, '0});
    rows.insert(rows.size(), '{ActInsert, 500, 600, 0, 1, mk(ST_FULL, 0, 0, 0, 16)});
    rows.insert(rows.size(), '{ActInsert, 12, 20, 0, 0, '0});   // touching endpoints
    rows.insert(rows.size(), '{ActInsert, 35, 145, 0, 0, '0});  // swallows inner entries
    rows.insert(rows.size(), '{ActInsert, 0, 32'hFFFF_FFFF, 0, 0, '0});
    rows.insert(rows.size(), '{ActRead, 0, 0, 4'd0, 0, '0});
    foreach (rows[i]) begin
      r = rows[i];
      send_item(r.action, r.lo, r.hi, r.idx, r.fixed, r.want);
    end

    // random phase: mostly small ranges for real overlap, occasional clearing
    for (int n = 0; n < 1500; n++) begin
      scale = (n % 300 < 150) ? 200 : 5000;
      a = rnd_point(scale);
      b = ($urandom_range(0, 15) == 0) ? rnd_point(scale) : a + $urandom_range(0, 12);
      if (b < a && $urandom_range(0, 3) != 0) b = 32'hFFFF_FFFF;
      if ($urandom_range(0, 3) == 0)
        send_item(ActRead, $urandom(), $urandom(), 4'($urandom_range(0, 15)), 0, '0);
      else if ($urandom_range(0, 199) == 0)
        send_item(ActInsert, 0, 32'hFFFF_FFFF, 4'($urandom()), 0, '0);
      else
        send_item(ActInsert, a, b, 4'($urandom()), 0, '0);
    end
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #8000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
